### rtl/core/srs_pkg.sv
`default_nettype none

package srs_pkg;

   // configuration register width and index codes
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_PERIOD   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMPLETION_TIME = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPPER_LIMIT     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWER_LIMIT     = 2'd3;

   // register reset values
   localparam logic [CFG_BITS-1:0] RST_SAMPLE_PERIOD   = 16'd10;
   localparam logic [CFG_BITS-1:0] RST_COMPLETION_TIME = 16'd1000;
   localparam logic [CFG_BITS-1:0] RST_UPPER_LIMIT     = 16'h7FFF;
   localparam logic [CFG_BITS-1:0] RST_LOWER_LIMIT     = 16'h8000;

   // wait phase gives up once more than this many ticks pass without a done report
   localparam int WAIT_TIMEOUT = 3000;
   // fewer samples than this go straight to the final update
   localparam int MIN_SAMPLES  = 2;

   // ramp controller phase
   typedef enum logic [2:0] {
      PH_INIT = 3'd0,
      PH_CALC = 3'd1,
      PH_INC  = 3'd2,
      PH_DEC  = 3'd3,
      PH_WAIT = 3'd4,
      PH_LAST = 3'd5
   } phase_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

### rtl/core/srs_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module srs_div #(
   parameter int DIVIDEND_BITS = 17,
   parameter int DIVISOR_BITS  = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [DIVIDEND_BITS-1:0]   dividend,
   input  wire logic [DIVISOR_BITS-1:0]    divisor,
   output srs_pkg::div_status_type         status,
   output logic      [DIVIDEND_BITS-1:0]   quotient
);
   import srs_pkg::*;

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff;
   logic                     done_ff;
   logic [CNT_BITS-1:0]      count_ff;
   logic [DIVISOR_BITS-1:0]  rem_ff;
   logic [DIVISOR_BITS-1:0]  divisor_ff;
   logic [DIVIDEND_BITS-1:0] quot_ff;

   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
      fits    = shifted >= {1'b0, divisor_ff};
      diff    = shifted - {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_BITS'(DIVIDEND_BITS);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quot_ff    <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
         quot_ff <= {quot_ff[DIVIDEND_BITS-2:0], fits};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

`default_nettype wire

### rtl/core/setpoint_ramp_sequencer.sv
// Flow: a request passes through the step state and the done state into the response
// register; a ramp start also runs one division and a calculation step up to two, on
// the bit-serial divider of DIV_BITS = max(VALUE_BITS + 1, 16) bits.
// Throughput: one request at a time; the next is taken once the step is finished.
// Reset: synchronous, active high; config returns to its defaults, the ramp
// goes to the init phase with no active target.
`default_nettype none

module setpoint_ramp_sequencer #(
   parameter int VALUE_BITS = 16,
   parameter int TIMER_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_tick,
   input  wire logic                                   req_target_valid,
   input  wire logic signed [VALUE_BITS-1:0]           req_target_request,
   input  wire logic                                   req_done_pulse,
   input  wire logic signed [VALUE_BITS-1:0]           req_measured_value,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_drive_valid,
   output logic signed      [VALUE_BITS-1:0]           rsp_drive_value,
   output logic                                        rsp_config_error,
   output logic                                        rsp_target_rejected,
   output logic                                        rsp_busy_res,
   // configuration write port
   input  wire logic                                   csr_write_en,
   input  wire logic        [srs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic        [srs_pkg::CFG_BITS-1:0]    csr_wdata
);
   import srs_pkg::*;

   localparam int CW       = ((VALUE_BITS > CFG_BITS) ? VALUE_BITS : CFG_BITS) + 2;
   localparam int TW       = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
   localparam int DIV_BITS = ((VALUE_BITS + 1) > CFG_BITS) ? (VALUE_BITS + 1) : CFG_BITS;
   localparam int PW       = 2 * CFG_BITS;
   localparam int NW       = PW + 2;
   localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_DIV_TOTAL,
      S_NUM,
      S_DIV_REM,
      S_DIST,
      S_DIV_STEP,
      S_DONE
   } state_type;

   // configuration registers
   logic        [CFG_BITS-1:0] sample_period_ff;
   logic        [CFG_BITS-1:0] completion_time_ff;
   logic signed [CFG_BITS-1:0] upper_limit_ff;
   logic signed [CFG_BITS-1:0] lower_limit_ff;

   // controller state
   state_type                     state_ff;
   phase_type                     phase_ff;
   logic        [TIMER_BITS-1:0]  timer_ff;
   logic                          target_active_ff;
   logic signed [VALUE_BITS-1:0]  target_level_ff;
   logic signed [VALUE_BITS-1:0]  present_level_ff;
   logic        [VALUE_BITS-1:0]  step_size_ff;
   logic        [CFG_BITS-1:0]    sample_total_ff;
   logic        [CFG_BITS-1:0]    sample_count_ff;
   logic                          done_flag_ff;

   // per-request working registers
   logic signed [VALUE_BITS-1:0]  meas_ff;
   logic                          rej_ff;
   logic                          res_drv_ff;
   logic signed [VALUE_BITS-1:0]  res_dval_ff;
   logic                          res_cerr_ff;
   logic        [PW-1:0]          prod_ff;
   logic        [CFG_BITS-1:0]    rem_ff;

   // divider interface
   logic                          div_start_ff;
   logic        [DIV_BITS-1:0]    div_dividend_ff;
   logic        [CFG_BITS-1:0]    div_divisor_ff;
   div_status_type                div_status;
   logic        [DIV_BITS-1:0]    div_quot;

   // response registers
   logic                          rsp_valid_ff;
   logic                          rsp_drive_valid_ff;
   logic signed [VALUE_BITS-1:0]  rsp_drive_value_ff;
   logic                          rsp_config_error_ff;
   logic                          rsp_target_rejected_ff;
   logic                          rsp_busy_res_ff;

   // combinational helpers
   logic                          accept;
   logic        [TIMER_BITS-1:0]  timer_pre;
   logic        [TIMER_BITS-1:0]  timer_post;
   logic signed [CW-1:0]          treq_x;
   logic signed [CW-1:0]          upper_x;
   logic signed [CW-1:0]          lower_x;
   logic signed [CW-1:0]          target_x;
   logic signed [CW-1:0]          present_x;
   logic signed [CW-1:0]          step_x;
   logic signed [CW-1:0]          nv_inc;
   logic signed [CW-1:0]          nv_dec;
   logic                          stop_inc;
   logic                          stop_dec;
   logic                          reject;
   logic                          timer_reached;
   logic                          wait_expired;
   logic                          bad_timing;
   logic                          last_sample;
   logic signed [NW-1:0]          num;
   logic                          num_pos;
   logic        [CFG_BITS-1:0]    sp_safe;
   logic signed [VALUE_BITS:0]    dist_s;
   logic        [VALUE_BITS-1:0]  step_sat;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // request pre-step: timer clear on a new target, then the tick
   always_comb begin
      timer_pre  = req_target_valid ? '0 : timer_ff;
      timer_post = (req_tick && (timer_pre != '1)) ? timer_pre + 1'b1 : timer_pre;
      treq_x     = CW'(req_target_request);
      upper_x    = CW'(upper_limit_ff);
      lower_x    = CW'(lower_limit_ff);
      reject     = req_target_valid && ((treq_x > upper_x) || (treq_x < lower_x));
   end

   // controller step arithmetic
   always_comb begin
      target_x      = CW'(target_level_ff);
      present_x     = CW'(present_level_ff);
      step_x        = $signed(CW'(step_size_ff));
      nv_inc        = present_x + step_x;
      nv_dec        = present_x - step_x;
      stop_inc      = (nv_inc >= upper_x) || (nv_inc >= target_x);
      stop_dec      = (nv_dec <= lower_x) || (nv_dec <= target_x);
      timer_reached = TW'(timer_ff) >= TW'(sample_period_ff);
      wait_expired  = TW'(timer_ff) > TW'(WAIT_TIMEOUT);
      bad_timing    = (sample_period_ff == '0) || (completion_time_ff < sample_period_ff);
      last_sample   = (sample_total_ff < CFG_BITS'(MIN_SAMPLES))
                   || (({1'b0, sample_count_ff} + 1'b1) == {1'b0, sample_total_ff});
      num           = $signed(NW'(completion_time_ff)) - $signed(NW'(prod_ff));
      num_pos       = !num[NW-1] && (num != '0);
      sp_safe       = (sample_period_ff == '0) ? CFG_BITS'(1) : sample_period_ff;
      dist_s        = (target_level_ff > present_level_ff)
                    ? ((VALUE_BITS+1)'(target_level_ff) - (VALUE_BITS+1)'(present_level_ff))
                    : ((VALUE_BITS+1)'(present_level_ff) - (VALUE_BITS+1)'(target_level_ff));
      step_sat      = (div_quot > DIV_BITS'(VMAX)) ? VMAX : div_quot[VALUE_BITS-1:0];
   end

   // shared divider
   srs_div #(
      .DIVIDEND_BITS (DIV_BITS),
      .DIVISOR_BITS  (CFG_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend_ff),
      .divisor  (div_divisor_ff),
      .status   (div_status),
      .quotient (div_quot)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff   <= RST_SAMPLE_PERIOD;
         completion_time_ff <= RST_COMPLETION_TIME;
         upper_limit_ff     <= $signed(RST_UPPER_LIMIT);
         lower_limit_ff     <= $signed(RST_LOWER_LIMIT);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_PERIOD:   sample_period_ff   <= csr_wdata;
            CSR_COMPLETION_TIME: completion_time_ff <= csr_wdata;
            CSR_UPPER_LIMIT:     upper_limit_ff     <= $signed(csr_wdata);
            CSR_LOWER_LIMIT:     lower_limit_ff     <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // sequencer: state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         phase_ff         <= PH_INIT;
         timer_ff         <= '0;
         target_active_ff <= 1'b0;
         target_level_ff  <= '0;
         present_level_ff <= '0;
         step_size_ff     <= '0;
         sample_total_ff  <= '0;
         sample_count_ff  <= '0;
         done_flag_ff     <= 1'b0;
         div_start_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         // drop the response once taken, unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  timer_ff <= timer_post;
                  if (req_target_valid) begin
                     phase_ff <= PH_INIT;
                  end
                  if (req_target_valid && !reject) begin
                     target_level_ff  <= req_target_request;
                     target_active_ff <= 1'b1;
                  end
                  if (req_done_pulse) begin
                     done_flag_ff <= 1'b1;
                  end
                  rej_ff      <= reject;
                  meas_ff     <= req_measured_value;
                  res_drv_ff  <= 1'b0;
                  res_dval_ff <= '0;
                  res_cerr_ff <= 1'b0;
                  state_ff    <= S_STEP;
               end
            end

            S_STEP: begin
               state_ff <= S_DONE;
               if (!target_active_ff) begin
                  phase_ff <= PH_INIT;
                  timer_ff <= '0;
               end else begin
                  unique case (phase_ff)
                     PH_INIT: begin
                        if (bad_timing) begin
                           res_cerr_ff      <= 1'b1;
                           res_drv_ff       <= 1'b1;
                           res_dval_ff      <= target_level_ff;
                           target_active_ff <= 1'b0;
                           timer_ff         <= '0;
                        end else begin
                           sample_count_ff <= '0;
                           step_size_ff    <= '0;
                           div_start_ff    <= 1'b1;
                           div_dividend_ff <= DIV_BITS'(completion_time_ff);
                           div_divisor_ff  <= sample_period_ff;
                           state_ff        <= S_DIV_TOTAL;
                        end
                     end
                     PH_CALC: begin
                        present_level_ff <= meas_ff;
                        if (last_sample) begin
                           phase_ff <= PH_LAST;
                           timer_ff <= '0;
                        end else begin
                           prod_ff  <= sample_count_ff * sample_period_ff;
                           state_ff <= S_NUM;
                        end
                     end
                     PH_INC, PH_DEC: begin
                        if (timer_reached) begin
                           timer_ff <= '0;
                           if ((phase_ff == PH_INC) ? stop_inc : stop_dec) begin
                              phase_ff <= PH_LAST;
                           end else begin
                              present_level_ff <= (phase_ff == PH_INC)
                                 ? nv_inc[VALUE_BITS-1:0] : nv_dec[VALUE_BITS-1:0];
                              res_drv_ff       <= 1'b1;
                              res_dval_ff      <= (phase_ff == PH_INC)
                                 ? nv_inc[VALUE_BITS-1:0] : nv_dec[VALUE_BITS-1:0];
                              sample_count_ff  <= sample_count_ff + 1'b1;
                              phase_ff         <= done_flag_ff ? PH_WAIT : PH_CALC;
                           end
                        end
                     end
                     PH_WAIT: begin
                        if (done_flag_ff || wait_expired) begin
                           phase_ff     <= PH_CALC;
                           timer_ff     <= '0;
                           done_flag_ff <= 1'b0;
                        end
                     end
                     PH_LAST: begin
                        if (timer_reached) begin
                           res_drv_ff       <= 1'b1;
                           res_dval_ff      <= target_level_ff;
                           target_active_ff <= 1'b0;
                           phase_ff         <= PH_INIT;
                           timer_ff         <= '0;
                        end
                     end
                     default: begin
                        phase_ff <= PH_INIT;
                        timer_ff <= '0;
                     end
                  endcase
               end
            end

            // sample total = completion time / period
            S_DIV_TOTAL: begin
               if (div_status.done) begin
                  sample_total_ff <= div_quot[CFG_BITS-1:0];
                  phase_ff        <= PH_CALC;
                  timer_ff        <= '0;
                  state_ff        <= S_DONE;
               end
            end

            // remaining time, then remaining samples
            S_NUM: begin
               if (num_pos) begin
                  div_start_ff    <= 1'b1;
                  div_dividend_ff <= DIV_BITS'(num[CFG_BITS-1:0]);
                  div_divisor_ff  <= sp_safe;
                  state_ff        <= S_DIV_REM;
               end else begin
                  rem_ff   <= CFG_BITS'(1);
                  state_ff <= S_DIST;
               end
            end

            S_DIV_REM: begin
               if (div_status.done) begin
                  rem_ff   <= (div_quot == '0) ? CFG_BITS'(1) : div_quot[CFG_BITS-1:0];
                  state_ff <= S_DIST;
               end
            end

            // step = distance / remaining samples
            S_DIST: begin
               div_start_ff    <= 1'b1;
               div_dividend_ff <= DIV_BITS'($unsigned(dist_s));
               div_divisor_ff  <= rem_ff;
               state_ff        <= S_DIV_STEP;
            end

            S_DIV_STEP: begin
               if (div_status.done) begin
                  step_size_ff <= step_sat;
                  timer_ff     <= '0;
                  if (step_sat == '0) begin
                     phase_ff <= PH_LAST;
                  end else if (target_level_ff > present_level_ff) begin
                     phase_ff <= PH_INC;
                  end else begin
                     phase_ff <= PH_DEC;
                  end
                  state_ff <= S_DONE;
               end
            end

            // hand the result to the response register once it is free
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_drive_valid_ff     <= res_drv_ff;
                  rsp_drive_value_ff     <= res_drv_ff ? res_dval_ff : '0;
                  rsp_config_error_ff    <= res_cerr_ff;
                  rsp_target_rejected_ff <= rej_ff;
                  rsp_busy_res_ff        <= target_active_ff;
                  state_ff               <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_valid     = rsp_drive_valid_ff;
   assign rsp_drive_value     = rsp_drive_value_ff;
   assign rsp_config_error    = rsp_config_error_ff;
   assign rsp_target_rejected = rsp_target_rejected_ff;
   assign rsp_busy_res        = rsp_busy_res_ff;

   // divider is never restarted while it is working
   assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> !div_status.busy)
      else $error("divider started while busy");

   // a request blocks the input until its step is finished
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted during a step");

   // with no active target the ramp rests in the init phase between requests
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && !target_active_ff |-> (phase_ff == PH_INIT))
      else $error("idle ramp left the init phase");

   // a saturated step never exceeds the largest positive value
   assert property (@(posedge clock) disable iff (reset)
      !step_size_ff[VALUE_BITS-1])
      else $error("step size out of range");

endmodule

`default_nettype wire
